@@ hw/rtl/circle_rasterizer_with_fill_assert.svh @@
// Assertion macros shared by the rasterizer RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef CIRCLE_RASTERIZER_WITH_FILL_ASSERT_SVH
`define CIRCLE_RASTERIZER_WITH_FILL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/crf_pkg.sv @@
// Shared constants and types for the circle rasterizer.
// No dependencies.
`default_nettype none

package crf_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int RADIUS_BITS_DEF = 9;
  localparam int OUT_BITS = 12;
  localparam int COLOR_BITS = 16;
  localparam int PIX_PER_POINT = 8;
  localparam int IDX_BITS = $clog2(PIX_PER_POINT);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

endpackage

`default_nettype wire

@@ hw/rtl/circle_rasterizer_with_fill.sv @@
// Circle rasterizer top level: Andres stepping, optional concentric fill.
// Depends on crf_pkg and circle_rasterizer_with_fill_assert.svh.
//
// Usage:
//  - Item channel (item_valid / item_stall): op = start loads center, radius,
//    color and fill mode and emits nothing; op = advance emits the eight
//    symmetric pixels of the current octant point and steps the decision term.
//  - Pixel channel (pixel_valid / pixel_stall): one pixel per transfer,
//    last_of_point on the eighth, figure_done on the last pixel of a figure.
//  - Latency: first pixel of an advance is valid the cycle after its transfer.
//  - Pacing: set by the single pixel output port, one pixel per transfer;
//    the next advance is taken in the same cycle the eighth pixel leaves.
//    Starts and advances while idle are taken at one per cycle when no
//    pixels are pending.
//  - Receiver stall holds the current pixel and, through item_stall, holds
//    off new items until the pending point has fully drained.
//  - Reset (rst, synchronous) clears all state but the held output point;
//    the rasterizer is idle and advances are ignored until a start arrives.
`default_nettype none

module circle_rasterizer_with_fill
  import crf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          op,
  input  wire logic [COORD_BITS-1:0]         center_x,
  input  wire logic [COORD_BITS-1:0]         center_y,
  input  wire logic [RADIUS_BITS-1:0]        radius,
  input  wire logic [COLOR_BITS-1:0]         pixel_color,
  input  wire logic                          filled,
  output logic                               pixel_valid,
  input  wire logic                          pixel_stall,
  output logic signed [OUT_BITS-1:0]         pixel_x,
  output logic signed [OUT_BITS-1:0]         pixel_y,
  output logic [COLOR_BITS-1:0]              color_out,
  output logic                               last_of_point,
  output logic                               figure_done
);

  localparam int DEC_BITS = RADIUS_BITS + 3;
  localparam int CALC_BITS = DEC_BITS + 2;
  localparam int STEP_BITS = RADIUS_BITS + 2;
  localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(PIX_PER_POINT - 1);
  localparam logic signed [CALC_BITS-1:0] CALC_ONE = CALC_BITS'(1);
  localparam logic signed [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1);
  localparam logic signed [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1);
  localparam logic [RADIUS_BITS-1:0] RAD_ONE = RADIUS_BITS'(1);

  // rasterizer state
  logic [COORD_BITS-1:0]        ctr_x, ctr_y;
  logic [RADIUS_BITS-1:0]       radius_now, step_x, step_y;
  logic signed [DEC_BITS-1:0]   decision;
  logic                         fill_mode;
  logic [COLOR_BITS-1:0]        held_color;
  logic                         busy;

  // pending point, drained one pixel per transfer
  logic                         pend;
  logic [IDX_BITS-1:0]          idx;
  logic [COORD_BITS-1:0]        o_cx, o_cy;
  logic [RADIUS_BITS-1:0]       o_x, o_y;
  logic [COLOR_BITS-1:0]        o_color;
  logic                         o_done;

  logic accept, capture, xfer, last_xfer;
  logic signed [CALC_BITS-1:0] d_w, x_w, y_w, r_w, nd_w;
  logic signed [STEP_BITS-1:0] xs_w, ys_w, nx_w, ny_w;
  logic circle_end, shrink;
  logic [RADIUS_BITS-1:0] radius_dec;

  function automatic logic signed [DEC_BITS-1:0] dec_init(input logic [RADIUS_BITS-1:0] r);
    dec_init = signed'(DEC_BITS'(r)) - DEC_ONE;
  endfunction

  assign xfer      = pixel_valid && !pixel_stall;
  assign last_xfer = xfer && (idx == LAST_IDX);
  assign item_stall = pend && !last_xfer;
  assign accept    = item_valid && !item_stall;
  assign capture   = accept && (op == OP_ADVANCE) && busy;

  // Andres step
  always_comb begin
    d_w  = CALC_BITS'(decision);
    x_w  = signed'(CALC_BITS'(step_x));
    y_w  = signed'(CALC_BITS'(step_y));
    r_w  = signed'(CALC_BITS'(radius_now));
    xs_w = signed'(STEP_BITS'(step_x));
    ys_w = signed'(STEP_BITS'(step_y));
    if (d_w >= (x_w <<< 1)) begin
      nd_w = d_w - (x_w <<< 1) - CALC_ONE;
      nx_w = xs_w + STEP_ONE;
      ny_w = ys_w;
    end else if (d_w < ((r_w - y_w) <<< 1)) begin
      nd_w = d_w + (y_w <<< 1) - CALC_ONE;
      nx_w = xs_w;
      ny_w = ys_w - STEP_ONE;
    end else begin
      nd_w = d_w + ((y_w - x_w - CALC_ONE) <<< 1);
      nx_w = xs_w + STEP_ONE;
      ny_w = ys_w - STEP_ONE;
    end
  end

  assign circle_end = ny_w < nx_w;
  assign shrink     = fill_mode && (radius_now != '0);
  assign radius_dec = radius_now - RAD_ONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_x      <= '0;
      ctr_y      <= '0;
      radius_now <= '0;
      step_x     <= '0;
      step_y     <= '0;
      decision   <= '0;
      fill_mode  <= 1'b0;
      held_color <= '0;
      busy       <= 1'b0;
      pend       <= 1'b0;
      idx        <= '0;
    end else begin
      if (accept && (op == OP_START)) begin
        ctr_x      <= center_x;
        ctr_y      <= center_y;
        radius_now <= radius;
        held_color <= pixel_color;
        fill_mode  <= filled;
        step_x     <= '0;
        step_y     <= radius;
        decision   <= dec_init(radius);
        busy       <= 1'b1;
      end else if (capture) begin
        if (circle_end) begin
          if (shrink) begin
            // next concentric ring
            radius_now <= radius_dec;
            step_x     <= '0;
            step_y     <= radius_dec;
            decision   <= dec_init(radius_dec);
          end else begin
            busy <= 1'b0;
          end
        end else begin
          step_x   <= nx_w[RADIUS_BITS-1:0];
          step_y   <= ny_w[RADIUS_BITS-1:0];
          decision <= nd_w[DEC_BITS-1:0];
        end
      end

      if (capture) begin
        pend <= 1'b1;
        idx  <= '0;
      end else if (xfer) begin
        idx <= idx + IDX_BITS'(1);
        if (idx == LAST_IDX) begin
          pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      o_cx    <= ctr_x;
      o_cy    <= ctr_y;
      o_x     <= step_x;
      o_y     <= step_y;
      o_color <= held_color;
      o_done  <= circle_end && !shrink;
    end
  end

  // Pixel order: idx[2] swaps x/y, idx[1] negates column offset,
  // idx[0] negates row offset.
  logic signed [SUM_BITS-1:0] cx_s, cy_s, a_s, b_s, px_s, py_s;

  always_comb begin
    cx_s = signed'(SUM_BITS'(o_cx));
    cy_s = signed'(SUM_BITS'(o_cy));
    a_s  = idx[2] ? signed'(SUM_BITS'(o_y)) : signed'(SUM_BITS'(o_x));
    b_s  = idx[2] ? signed'(SUM_BITS'(o_x)) : signed'(SUM_BITS'(o_y));
    px_s = idx[1] ? (cx_s - a_s) : (cx_s + a_s);
    py_s = idx[0] ? (cy_s - b_s) : (cy_s + b_s);
  end

  assign pixel_valid   = pend;
  assign pixel_x       = OUT_BITS'(px_s);
  assign pixel_y       = OUT_BITS'(py_s);
  assign color_out     = o_color;
  assign last_of_point = (idx == LAST_IDX);
  assign figure_done   = o_done && last_of_point;

  `include "circle_rasterizer_with_fill_assert.svh"

  `CRF_ASSERT_NOW(a_no_overrun, clk, rst, capture && pend, last_xfer, "advance overran pending point")
  `CRF_ASSERT_NOW(a_done_on_last, clk, rst, pixel_valid && figure_done, last_of_point, "figure_done off last pixel")
  `CRF_ASSERT_NEXT(a_drain, clk, rst, last_xfer && !capture, !pixel_valid, "pixel valid after drain")
  `CRF_ASSERT_NOW(a_octant, clk, rst, busy, step_y >= step_x, "step left the octant")
  `CRF_ASSERT_NEXT(a_idle_start, clk, rst, capture, pixel_valid && (idx == '0), "point not loaded")

endmodule

`default_nettype wire
